### sv/lcru_pkg.sv
// shared types, constants and register codes of the cell rule unit
package lcru_pkg;

  localparam int unsigned NbW       = 9;   // 3x3 neighbourhood word
  localparam int unsigned CentreBit = 4;
  localparam int unsigned MaskW     = 9;   // one bit per moore count 0..8
  localparam int unsigned HexClassN = 13;
  localparam int unsigned HexClassW = $clog2(HexClassN);
  localparam int unsigned CntW      = $clog2(MaskW);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = HexClassN;

  localparam logic [MaskW-1:0]     BirthReset      = 9'd8;
  localparam logic [MaskW-1:0]     SurviveReset    = 9'd12;
  localparam logic [HexClassN-1:0] HexBirthReset   = 13'd4;
  localparam logic [HexClassN-1:0] HexSurviveReset = 13'd2024;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEX_MODE     = 3'd0,
    REG_BIRTH        = 3'd1,
    REG_SURVIVE      = 3'd2,
    REG_HEX_BIRTH    = 3'd3,
    REG_HEX_SURVIVE  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_ON   = 2'd1,
    CHG_OFF  = 2'd2
  } change_e;

  typedef enum logic [HexClassW-1:0] {
    HC_ZERO      = 4'd0,
    HC_ONE       = 4'd1,
    HC_TWO_ORTHO = 4'd2,
    HC_TWO_META  = 4'd3,
    HC_TWO_PARA  = 4'd4,
    HC_THR_ROW   = 4'd5,
    HC_THR_OTHER = 4'd6,
    HC_THR_ALT   = 4'd7,
    HC_FOUR_ORTHO = 4'd8,
    HC_FOUR_META = 4'd9,
    HC_FOUR_PARA = 4'd10,
    HC_FIVE      = 4'd11,
    HC_SIX       = 4'd12
  } hex_class_e;

  typedef struct packed {
    logic                 hex_mode;
    logic [MaskW-1:0]     birth_mask;
    logic [MaskW-1:0]     survive_mask;
    logic [HexClassN-1:0] hex_birth_table;
    logic [HexClassN-1:0] hex_survive_table;
  } rule_cfg_t;

endpackage

### sv/lcru_hex_class.sv
// sorts the six hex ring neighbours into one of thirteen arrangement classes
module lcru_hex_class (
  input  logic [lcru_pkg::NbW-1:0] neighborhood_i,
  output lcru_pkg::hex_class_e     hex_class_o
);
  import lcru_pkg::*;

  logic [5:0] ring;
  logic [5:0] gaps;
  logic [5:0] rot1, rot2, grot1, grot2;
  logic [2:0] live_n;

  // ring order 0,1,5,8,7,3; bits 2 and 6 play no part
  assign ring = {neighborhood_i[3], neighborhood_i[7], neighborhood_i[8],
                 neighborhood_i[5], neighborhood_i[1], neighborhood_i[0]};
  assign gaps   = ~ring;
  assign rot1   = {ring[4:0], ring[5]};
  assign rot2   = {ring[3:0], ring[5:4]};
  assign grot1  = {gaps[4:0], gaps[5]};
  assign grot2  = {gaps[3:0], gaps[5:4]};
  assign live_n = 3'($countones(ring));

  always_comb begin
    unique case (live_n)
      3'd0: hex_class_o = HC_ZERO;
      3'd1: hex_class_o = HC_ONE;
      3'd2: begin
        if ((ring & rot1) != 6'd0)      hex_class_o = HC_TWO_ORTHO;
        else if ((ring & rot2) != 6'd0) hex_class_o = HC_TWO_META;
        else                            hex_class_o = HC_TWO_PARA;
      end
      3'd3: begin
        if (ring == 6'h15 || ring == 6'h2A)       hex_class_o = HC_THR_ALT;
        else if ((ring & rot1 & rot2) != 6'd0)    hex_class_o = HC_THR_ROW;
        else                                      hex_class_o = HC_THR_OTHER;
      end
      3'd4: begin
        // classed by the two dead ring cells
        if ((gaps & grot1) != 6'd0)      hex_class_o = HC_FOUR_ORTHO;
        else if ((gaps & grot2) != 6'd0) hex_class_o = HC_FOUR_META;
        else                             hex_class_o = HC_FOUR_PARA;
      end
      3'd5: hex_class_o = HC_FIVE;
      default: hex_class_o = HC_SIX;
    endcase
  end

endmodule

### sv/lcru_rule_eval.sv
// applies the moore or hex rule tables and forms the change code
module lcru_rule_eval (
  input  logic [lcru_pkg::NbW-1:0] neighborhood_i,
  input  lcru_pkg::hex_class_e     hex_class_i,
  input  lcru_pkg::rule_cfg_t      cfg_i,
  output logic                     next_alive_o,
  output lcru_pkg::change_e        change_o
);
  import lcru_pkg::*;

  logic            centre;
  logic [7:0]      outer;
  logic [CntW-1:0] moore_cnt;
  logic            moore_next, hex_next;

  assign centre    = neighborhood_i[CentreBit];
  assign outer     = {neighborhood_i[8:5], neighborhood_i[3:0]};
  assign moore_cnt = CntW'($countones(outer));

  assign moore_next = centre ? cfg_i.survive_mask[moore_cnt]
                             : cfg_i.birth_mask[moore_cnt];
  assign hex_next   = centre ? cfg_i.hex_survive_table[hex_class_i]
                             : cfg_i.hex_birth_table[hex_class_i];

  assign next_alive_o = cfg_i.hex_mode ? hex_next : moore_next;

  always_comb begin
    if (next_alive_o == centre) change_o = CHG_NONE;
    else if (next_alive_o)      change_o = CHG_ON;
    else                        change_o = CHG_OFF;
  end

endmodule

### sv/life_cell_rule_unit.sv
// top level of the cell rule unit: config registers, input and result registers
// an accepted word passes the input register, then the result register, and then shows
//   on the result ports with done_o, one cycle wide
// throughput: one word every cycle, busy stays low; set by the single
//   register-to-register pass through class sort and table lookup
// reset: rule registers return to b3/s23 and the default hex tables, moore mode,
//   pipeline empty; the receiver cannot stall, so no result is ever held back
module life_cell_rule_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lcru_pkg::NbW-1:0]      neighborhood_i,
  output logic                          done_o,
  output logic                          next_alive_o,
  output logic [1:0]                    change_code_o,
  input  logic                          cfg_we_i,
  input  logic [lcru_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcru_pkg::CfgDataW-1:0] cfg_data_i
);
  import lcru_pkg::*;

  // rule registers
  rule_cfg_t cfg_q, cfg_d;

  // input stage
  logic           in_vld_q, in_vld_d;
  logic [NbW-1:0] nb_q, nb_d;

  // result stage
  logic    done_q, done_d;
  logic    alive_q, alive_d;
  change_e chg_q, chg_d;

  hex_class_e hex_class;
  logic       next_alive;
  change_e    change;
  logic       accept;

  // every cycle is free, so a word is taken whenever start is raised
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // config write, value cut to the register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEX_MODE:    cfg_d.hex_mode          = cfg_data_i[0];
        REG_BIRTH:       cfg_d.birth_mask        = cfg_data_i[MaskW-1:0];
        REG_SURVIVE:     cfg_d.survive_mask      = cfg_data_i[MaskW-1:0];
        REG_HEX_BIRTH:   cfg_d.hex_birth_table   = cfg_data_i[HexClassN-1:0];
        REG_HEX_SURVIVE: cfg_d.hex_survive_table = cfg_data_i[HexClassN-1:0];
        default: ;  // index past the list is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hex_mode          <= 1'b0;
      cfg_q.birth_mask        <= BirthReset;
      cfg_q.survive_mask      <= SurviveReset;
      cfg_q.hex_birth_table   <= HexBirthReset;
      cfg_q.hex_survive_table <= HexSurviveReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input register: capture the neighbourhood word on accept
  assign in_vld_d = accept;
  assign nb_d     = accept ? neighborhood_i : nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q <= nb_d;
  end

  // rule logic between the two register stages
  lcru_hex_class u_hex_class (
    .neighborhood_i (nb_q),
    .hex_class_o    (hex_class)
  );

  lcru_rule_eval u_rule_eval (
    .neighborhood_i (nb_q),
    .hex_class_i    (hex_class),
    .cfg_i          (cfg_q),
    .next_alive_o   (next_alive),
    .change_o       (change)
  );

  // result register: strobe is one cycle per word
  assign done_d  = in_vld_q;
  assign alive_d = in_vld_q ? next_alive : alive_q;
  assign chg_d   = in_vld_q ? change : chg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alive_q <= alive_d;
    chg_q   <= chg_d;
  end

  assign done_o        = done_q;
  assign next_alive_o  = alive_q;
  assign change_code_o = chg_q;

endmodule

### sv/lcru_checker.sv
// port-level checker for the cell rule unit and its bind
module lcru_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [lcru_pkg::NbW-1:0]      neighborhood_i,
  input logic                          done_o,
  input logic                          next_alive_o,
  input logic [1:0]                    change_code_o
);
  import lcru_pkg::*;

  // every accepted word gives a result once it has passed the input and result registers
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted word gave no result");

  // no result without a matching accept
  a_done_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  // change code agrees with old centre and new state
  a_change_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      ((change_code_o == CHG_NONE) && (next_alive_o == $past(neighborhood_i[CentreBit], 2)))
      || ((change_code_o == CHG_ON) && next_alive_o
          && !$past(neighborhood_i[CentreBit], 2))
      || ((change_code_o == CHG_OFF) && !next_alive_o
          && $past(neighborhood_i[CentreBit], 2)))
    else $error("change code disagrees with centre and next state");

  // the unit never refuses a word
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("busy raised");

endmodule

bind life_cell_rule_unit lcru_checker u_lcru_checker (.*);
